>>> rtl/mkced_pkg.sv
// Shared constants and event flag encoding for the multi-key click event detector.
`timescale 1ns / 1ps

package mkced_pkg;

  // Number of key lines watched (1 to 32).
  localparam int unsigned NUM_KEYS = 8;
  localparam int unsigned KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // Width of the raw level input; keys beyond it read the released level.
  localparam int unsigned LEVEL_W  = 8;

  localparam int unsigned FLAG_W   = 7;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Event flag bits.
  localparam logic [FLAG_W-1:0] EV_HOLD   = 7'h01;
  localparam logic [FLAG_W-1:0] EV_DOWN   = 7'h02;
  localparam logic [FLAG_W-1:0] EV_UP     = 7'h04;
  localparam logic [FLAG_W-1:0] EV_SINGLE = 7'h08;
  localparam logic [FLAG_W-1:0] EV_DOUBLE = 7'h10;
  localparam logic [FLAG_W-1:0] EV_LONG   = 7'h20;
  localparam logic [FLAG_W-1:0] EV_REPEAT = 7'h40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL_TIME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LVL = 3'd4;

  // Input item kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

endpackage

>>> rtl/multi_key_click_event_detector.sv
// Multi-key click event detector: top level with key sweep sequencer and shared key update unit.
// Sequencing: a tick transaction sweeps the keys one per cycle through the shared update unit
//   and then shows the result strobe; a check transaction passes through the check state.
// Transactions do not overlap: start is refused while busy and is taken again in the cycle
//   the result strobe is shown. The receiver cannot stall.
// Reset: asynchronous, active low; clears all flags, timers and click states, restores the
//   configuration defaults and sets stored levels to the released level.
`timescale 1ns / 1ps

module multi_key_click_event_detector
  import mkced_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind_i,
  input  logic [LEVEL_W-1:0]    key_levels_i,
  input  logic [7:0]            key_number_i,
  input  logic [FLAG_W-1:0]     event_mask_i,
  // Result channel
  output logic                  valid_o,
  output logic                  hit_o,
  output logic [FLAG_W-1:0]     flags_now_o,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SWEEP,
    SEQ_CHECK
  } seq_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PRESSED,
    CS_RELEASED,
    CS_DOUBLE,
    CS_LONG
  } click_e;

  // Configuration registers
  logic [7:0]         debounce_q;
  logic [TIMER_W-1:0] long_time_q;
  logic [TIMER_W-1:0] dbl_time_q;
  logic [TIMER_W-1:0] rpt_time_q;
  logic               press_lvl_q;

  // Per-key state, held in flops; the previous level is taken from lvl_now_q on the fly
  logic [FLAG_W-1:0]  flags_q     [NUM_KEYS];
  logic [TIMER_W-1:0] timer_q     [NUM_KEYS];
  click_e             click_q     [NUM_KEYS];
  logic               lvl_now_q   [NUM_KEYS];
  logic [7:0]         sample_cnt_q;

  // Sequencer and captured transaction
  seq_e               seq_q;
  logic [KEY_W-1:0]   idx_q;
  logic               sample_q;
  logic [LEVEL_W-1:0] levels_q;
  logic [KEY_W-1:0]   key_q;
  logic               in_range_q;
  logic [FLAG_W-1:0]  mask_q;
  logic [FLAG_W-1:0]  res_flags_q;

  // Registered outputs
  logic               valid_q;
  logic               hit_q;
  logic [FLAG_W-1:0]  flags_out_q;

  // Accept decode
  logic               accept;
  logic [7:0]         cnt_inc;
  logic               sample_now;

  // Shared key update unit: works on key idx_q
  logic [FLAG_W-1:0]  cur_flags;
  logic [TIMER_W-1:0] cur_timer;
  click_e             cur_click;
  logic               cur_prev;
  logic [TIMER_W-1:0] tmr_dec;
  logic [LEVEL_W-1:0] lvl_shift;
  logic               rel_lvl;
  logic               raw_lvl;
  logic               is_pressed;
  logic [FLAG_W-1:0]  flags_d;
  logic [TIMER_W-1:0] timer_d;
  click_e             click_d;
  logic               last_key;
  logic               key_match;

  // Check unit
  logic               chk_hit;
  logic [FLAG_W-1:0]  chk_flags;

  assign accept     = start && !busy;
  assign busy       = (seq_q != SEQ_IDLE);
  assign valid_o    = valid_q;
  assign hit_o      = hit_q;
  assign flags_now_o = flags_out_q;

  // Sample on this tick once the counter reaches the debounce period
  assign cnt_inc    = sample_cnt_q + 8'd1;
  assign sample_now = !(cnt_inc < debounce_q);

  assign cur_flags  = flags_q[idx_q];
  assign cur_timer  = timer_q[idx_q];
  assign cur_click  = click_q[idx_q];
  assign cur_prev   = lvl_now_q[idx_q];
  assign last_key   = (idx_q == KEY_W'(NUM_KEYS - 1));
  assign key_match  = in_range_q && (idx_q == key_q);

  // Keys beyond the level input read the released level
  assign rel_lvl    = ~press_lvl_q;
  assign lvl_shift  = levels_q >> idx_q;
  assign raw_lvl    = (32'(idx_q) < 32'(LEVEL_W)) ? lvl_shift[0] : rel_lvl;
  assign is_pressed = (raw_lvl == press_lvl_q);

  // Count the timer down first; the click machine sees the decremented value
  assign tmr_dec    = (cur_timer != '0) ? cur_timer - TIMER_W'(1) : cur_timer;

  always_comb begin
    flags_d = cur_flags;
    timer_d = tmr_dec;
    click_d = cur_click;
    if (sample_q) begin
      if (is_pressed) begin
        flags_d = flags_d | EV_HOLD;
      end else begin
        flags_d = flags_d & ~EV_HOLD;
      end
      if (is_pressed && (cur_prev == rel_lvl)) begin
        flags_d = flags_d | EV_DOWN;
      end
      if (!is_pressed && (cur_prev == press_lvl_q)) begin
        flags_d = flags_d | EV_UP;
      end
      case (cur_click)
        CS_IDLE: begin
          if (is_pressed) begin
            click_d = CS_PRESSED;
            timer_d = long_time_q;
          end
        end
        CS_PRESSED: begin
          if (!is_pressed) begin
            click_d = CS_RELEASED;
            timer_d = dbl_time_q;
          end else if (tmr_dec == '0) begin
            click_d = CS_LONG;
            timer_d = rpt_time_q;
            flags_d = flags_d | EV_LONG;
          end
        end
        CS_RELEASED: begin
          if (is_pressed) begin
            click_d = CS_DOUBLE;
            flags_d = flags_d | EV_DOUBLE;
          end else if (tmr_dec == '0) begin
            click_d = CS_IDLE;
            flags_d = flags_d | EV_SINGLE;
          end
        end
        CS_DOUBLE: begin
          if (!is_pressed) begin
            click_d = CS_IDLE;
          end
        end
        CS_LONG: begin
          if (!is_pressed) begin
            click_d = CS_IDLE;
          end else if (tmr_dec == '0) begin
            flags_d = flags_d | EV_REPEAT;
            timer_d = rpt_time_q;
          end
        end
        default: begin
          click_d = CS_IDLE;
        end
      endcase
    end
  end

  // Check: a hit clears the masked flags, unless the mask is hold alone
  assign chk_hit   = |(cur_flags & mask_q);
  assign chk_flags = (chk_hit && (mask_q != EV_HOLD)) ? (cur_flags & ~mask_q) : cur_flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= 8'd10;
      long_time_q  <= 16'd1000;
      dbl_time_q   <= 16'd300;
      rpt_time_q   <= 16'd100;
      press_lvl_q  <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        flags_q[k]    <= '0;
        timer_q[k]    <= '0;
        click_q[k]    <= CS_IDLE;
        lvl_now_q[k]  <= 1'b1;
      end
      sample_cnt_q <= '0;
      seq_q        <= SEQ_IDLE;
      idx_q        <= '0;
      sample_q     <= 1'b0;
      levels_q     <= '0;
      key_q        <= '0;
      in_range_q   <= 1'b0;
      mask_q       <= '0;
      res_flags_q  <= '0;
      valid_q      <= 1'b0;
      hit_q        <= 1'b0;
      flags_out_q  <= '0;
    end else begin
      valid_q <= 1'b0;

      // Configuration writes; indexes beyond the list are dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEBOUNCE:  debounce_q  <= cfg_data_i[7:0];
          CFG_LONG_TIME: long_time_q <= cfg_data_i;
          CFG_DBL_TIME:  dbl_time_q  <= cfg_data_i;
          CFG_RPT_TIME:  rpt_time_q  <= cfg_data_i;
          CFG_PRESS_LVL: press_lvl_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      case (seq_q)
        SEQ_IDLE: begin
          if (accept) begin
            levels_q    <= key_levels_i;
            key_q       <= key_number_i[KEY_W-1:0];
            in_range_q  <= (key_number_i < 8'(NUM_KEYS));
            mask_q      <= event_mask_i;
            res_flags_q <= '0;
            if (kind_i == KIND_TICK) begin
              // Settle the debounce decision once per tick, then sweep the keys
              sample_q     <= sample_now;
              sample_cnt_q <= sample_now ? 8'd0 : cnt_inc;
              idx_q        <= '0;
              seq_q        <= SEQ_SWEEP;
            end else begin
              idx_q <= key_number_i[KEY_W-1:0];
              seq_q <= SEQ_CHECK;
            end
          end
        end
        SEQ_SWEEP: begin
          // Advance one key through the shared update unit
          flags_q[idx_q] <= flags_d;
          timer_q[idx_q] <= timer_d;
          click_q[idx_q] <= click_d;
          if (sample_q) begin
            lvl_now_q[idx_q] <= raw_lvl;
          end
          if (key_match) begin
            res_flags_q <= flags_d;
          end
          if (last_key) begin
            valid_q     <= 1'b1;
            hit_q       <= 1'b0;
            flags_out_q <= key_match ? flags_d : res_flags_q;
            seq_q       <= SEQ_IDLE;
          end else begin
            idx_q <= idx_q + KEY_W'(1);
          end
        end
        SEQ_CHECK: begin
          valid_q <= 1'b1;
          seq_q   <= SEQ_IDLE;
          if (in_range_q) begin
            flags_q[idx_q] <= chk_flags;
            hit_q          <= chk_hit;
            flags_out_q    <= chk_flags;
          end else begin
            hit_q       <= 1'b0;
            flags_out_q <= '0;
          end
        end
        default: begin
          seq_q <= SEQ_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/mkced_checker.sv
// Port-level checker for the multi-key click event detector, bound to the top level.
`timescale 1ns / 1ps

module mkced_checker
  import mkced_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              kind_i,
  input logic              valid_o,
  input logic              hit_o,
  input logic [FLAG_W-1:0] flags_now_o
);

  // A result is only shown once the sequencer is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  // Every finished transaction ends in a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("busy dropped without a result");

  // A check transaction answers through the check state, with its result registered on leaving it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_CHECK)) |=> ##1 valid_o)
    else $error("check result late or missing");

  // A tick sweeps every key once before answering, and answers with hit clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_TICK)) |-> ##(NUM_KEYS + 1) (valid_o && !hit_o))
    else $error("tick result late, missing or with hit set");

  // While hit is shown outside a strobe, the result flags hold steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o && !valid_o |-> $stable(flags_now_o))
    else $error("result flags moved outside a strobe");

endmodule

bind multi_key_click_event_detector mkced_checker u_mkced_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .kind_i      (kind_i),
  .valid_o     (valid_o),
  .hit_o       (hit_o),
  .flags_now_o (flags_now_o)
);

>>> verif/tb_top.sv
// Self-checking testbench for the multi-key click event detector.
`timescale 1ns / 1ps
module tb_top;
  import mkced_pkg::*;

  // Generous ceiling on the whole run: every transaction plus the sender's gaps fits well below it.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Settle time after the last result before the verdict.
  localparam int unsigned DRAIN_CYCLES = 2 * (NUM_KEYS + 1);
  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  // Longest press or release run the key-level generator makes, in ticks.
  localparam int unsigned RUN_CAP = 600;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PRESSED,
    CS_RELEASED,
    CS_DOUBLE,
    CS_LONG
  } click_state_e;

  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] levels;
    logic [7:0]         key;
    logic [FLAG_W-1:0]  mask;
  } key_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [FLAG_W-1:0] flags;
  } flag_report_t;

  // Block ports; every input starts at a known value.
  logic                  clk_i;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic                  busy;
  logic                  kind_i       = KIND_TICK;
  logic [LEVEL_W-1:0]    key_levels_i = '0;
  logic [7:0]            key_number_i = '0;
  logic [FLAG_W-1:0]     event_mask_i = '0;
  logic                  valid_o;
  logic                  hit_o;
  logic [FLAG_W-1:0]     flags_now_o;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = CFG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  multi_key_click_event_detector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .key_levels_i (key_levels_i),
    .key_number_i (key_number_i),
    .event_mask_i (event_mask_i),
    .valid_o      (valid_o),
    .hit_o        (hit_o),
    .flags_now_o  (flags_now_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Commands waiting to be driven, and reports the block still owes us, oldest first.
  key_cmd_t     key_cmd_q[$];
  flag_report_t report_q[$];

  int unsigned gap_pct     = 0;
  int unsigned cycle_count = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_checks    = 0;
  int unsigned n_hits      = 0;
  int unsigned n_errors    = 0;

  // Shadow copy of the configuration registers.
  logic [7:0]         sh_debounce;
  logic [TIMER_W-1:0] sh_long_time;
  logic [TIMER_W-1:0] sh_dbl_time;
  logic [TIMER_W-1:0] sh_rpt_time;
  logic               sh_press_lvl;

  // Shadow copy of the per-key state.
  logic [FLAG_W-1:0]  sh_flags    [NUM_KEYS];
  logic [TIMER_W-1:0] sh_timer    [NUM_KEYS];
  click_state_e       sh_state    [NUM_KEYS];
  logic               sh_lvl      [NUM_KEYS];
  logic               sh_lvl_prev [NUM_KEYS];
  logic [7:0]         sh_samp_cnt;

  // Key-level generator: each line holds its level for a random run of ticks.
  logic [LEVEL_W-1:0] gen_level = '1;
  int unsigned        gen_run [LEVEL_W];
  int unsigned        gen_short_run = 4;
  int unsigned        gen_long_run  = 20;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle counter; give up once the run is far beyond any correct duration.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void shadow_reset();
    int k;
    sh_debounce  = 8'd10;
    sh_long_time = 16'd1000;
    sh_dbl_time  = 16'd300;
    sh_rpt_time  = 16'd100;
    sh_press_lvl = 1'b0;
    for (k = 0; k < NUM_KEYS; k++) begin
      sh_flags[k]    = '0;
      sh_timer[k]    = '0;
      sh_state[k]    = CS_IDLE;
      // Stored levels are raw line bits: released under the reset polarity.
      sh_lvl[k]      = 1'b1;
      sh_lvl_prev[k] = 1'b1;
    end
    sh_samp_cnt = '0;
  endfunction

  // Take one level sample for key k: update the edge and hold flags, then advance
  // the click state machine.
  function automatic void sample_key(int k, logic [LEVEL_W-1:0] levels);
    logic raw;
    logic down;
    // Lines beyond the level input always read released.
    raw = (k < LEVEL_W) ? levels[k] : ~sh_press_lvl;
    sh_lvl_prev[k] = sh_lvl[k];
    sh_lvl[k]      = raw;
    down           = (raw == sh_press_lvl);

    if (down) begin
      sh_flags[k] |= EV_HOLD;
    end else begin
      sh_flags[k] &= ~EV_HOLD;
    end
    if (down && sh_lvl_prev[k] != sh_press_lvl) sh_flags[k] |= EV_DOWN;
    if (!down && sh_lvl_prev[k] == sh_press_lvl) sh_flags[k] |= EV_UP;

    case (sh_state[k])
      CS_IDLE: begin
        if (down) begin
          sh_state[k] = CS_PRESSED;
          sh_timer[k] = sh_long_time;
        end
      end
      CS_PRESSED: begin
        if (!down) begin
          sh_state[k] = CS_RELEASED;
          sh_timer[k] = sh_dbl_time;
        end else if (sh_timer[k] == '0) begin
          sh_state[k] = CS_LONG;
          sh_timer[k] = sh_rpt_time;
          sh_flags[k] |= EV_LONG;
        end
      end
      CS_RELEASED: begin
        if (down) begin
          sh_state[k] = CS_DOUBLE;
          sh_flags[k] |= EV_DOUBLE;
        end else if (sh_timer[k] == '0) begin
          sh_state[k] = CS_IDLE;
          sh_flags[k] |= EV_SINGLE;
        end
      end
      CS_DOUBLE: begin
        if (!down) sh_state[k] = CS_IDLE;
      end
      CS_LONG: begin
        if (!down) begin
          sh_state[k] = CS_IDLE;
        end else if (sh_timer[k] == '0) begin
          sh_flags[k] |= EV_REPEAT;
          sh_timer[k] = sh_rpt_time;
        end
      end
      default: begin
        sh_state[k] = CS_IDLE;
      end
    endcase
  endfunction

  // Apply one accepted command to the shadow state and return the report it earns.
  function automatic flag_report_t predict_report(key_cmd_t cmd);
    flag_report_t rep;
    int           k;
    rep = '0;
    if (cmd.kind == KIND_TICK) begin
      // Timers run on every tick, sampling only on the debounce boundary.
      for (k = 0; k < NUM_KEYS; k++) begin
        if (sh_timer[k] != '0) sh_timer[k] = sh_timer[k] - 1'b1;
      end
      sh_samp_cnt = sh_samp_cnt + 8'd1;
      if (sh_samp_cnt >= sh_debounce) begin
        sh_samp_cnt = '0;
        for (k = 0; k < NUM_KEYS; k++) sample_key(k, cmd.levels);
      end
      if (cmd.key < NUM_KEYS) rep.flags = sh_flags[cmd.key];
    end else if (cmd.key < NUM_KEYS) begin
      if ((sh_flags[cmd.key] & cmd.mask) != '0) begin
        // A hold-only mask peeks without clearing.
        if (cmd.mask != EV_HOLD) sh_flags[cmd.key] &= ~cmd.mask;
        rep.hit = 1'b1;
      end
      rep.flags = sh_flags[cmd.key];
    end
    return rep;
  endfunction

  function automatic key_cmd_t tick_cmd(logic [LEVEL_W-1:0] levels, logic [7:0] key);
    key_cmd_t cmd;
    cmd        = '0;
    cmd.kind   = KIND_TICK;
    cmd.levels = levels;
    cmd.key    = key;
    return cmd;
  endfunction

  function automatic key_cmd_t check_cmd(logic [7:0] key, logic [FLAG_W-1:0] mask);
    key_cmd_t cmd;
    cmd      = '0;
    cmd.kind = KIND_CHECK;
    cmd.key  = key;
    cmd.mask = mask;
    return cmd;
  endfunction

  // Mostly ticks carrying well-formed press and release runs, with a few noisy level
  // words, and checks with masks biased towards single events and the hold peek.
  function automatic key_cmd_t random_cmd();
    key_cmd_t    cmd;
    int unsigned pick;
    int          k;
    logic [7:0]  key;
    key = ($urandom_range(99) < 88) ? 8'($urandom_range(NUM_KEYS - 1)) : 8'($urandom);
    if ($urandom_range(99) < 70) begin
      cmd = tick_cmd(gen_level, key);
      cmd.mask = FLAG_W'($urandom);
      if ($urandom_range(99) < 5) begin
        cmd.levels = LEVEL_W'($urandom);
      end else begin
        for (k = 0; k < LEVEL_W; k++) begin
          if (gen_run[k] == 0) begin
            gen_level[k] = ~gen_level[k];
            gen_run[k] = ($urandom_range(1) == 0) ? $urandom_range(gen_short_run, 1)
                                                  : $urandom_range(gen_long_run, 1);
          end
          gen_run[k]--;
        end
        cmd.levels = gen_level;
      end
    end else begin
      cmd = check_cmd(key, '0);
      cmd.levels = LEVEL_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
        cmd.mask = EV_HOLD << $urandom_range(FLAG_W - 1);
      end else if (pick < 55) begin
        cmd.mask = EV_HOLD;
      end else if (pick < 60) begin
        cmd.mask = '0;
      end else if (pick < 70) begin
        cmd.mask = '1;
      end else begin
        cmd.mask = FLAG_W'($urandom);
      end
    end
    return cmd;
  endfunction

  // Drive one register write; the block takes it at the next rising edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_DEBOUNCE:  sh_debounce  = data[7:0];
      CFG_LONG_TIME: sh_long_time = data[TIMER_W-1:0];
      CFG_DBL_TIME:  sh_dbl_time  = data[TIMER_W-1:0];
      CFG_RPT_TIME:  sh_rpt_time  = data[TIMER_W-1:0];
      CFG_PRESS_LVL: sh_press_lvl = data[0];
      default: ;
    endcase
  endtask

  // Write every register back to back, then retune the level generator so its runs
  // straddle the new timer loads.
  task automatic configure(input logic [7:0] debounce, input logic [TIMER_W-1:0] long_t,
                           input logic [TIMER_W-1:0] dbl_t, input logic [TIMER_W-1:0] rpt_t,
                           input logic press_lvl, input bit poke_spare);
    if (poke_spare) write_reg(CFG_SPARE_IDX, '1);
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(debounce));
    write_reg(CFG_LONG_TIME, long_t);
    write_reg(CFG_DBL_TIME, dbl_t);
    write_reg(CFG_RPT_TIME, rpt_t);
    write_reg(CFG_PRESS_LVL, CFG_DATA_W'(press_lvl));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_short_run = 2 * (int'(debounce) + 1) + int'(dbl_t);
    gen_long_run  = int'(long_t) + 4 * int'(rpt_t) + 2 * (int'(debounce) + 1);
    if (gen_short_run > RUN_CAP) gen_short_run = RUN_CAP;
    if (gen_long_run > RUN_CAP) gen_long_run = RUN_CAP;
  endtask

  // Hold until every queued command is accepted and every report has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (key_cmd_q.size() != 0 || start || report_q.size() != 0);
  endtask

  // Reconfigure while idle, set the sender gap rate, then queue a batch of random commands.
  task automatic run_phase(input int unsigned gap, input logic [7:0] debounce,
                           input logic [TIMER_W-1:0] long_t, input logic [TIMER_W-1:0] dbl_t,
                           input logic [TIMER_W-1:0] rpt_t, input logic press_lvl,
                           input bit poke_spare, input int n);
    wait_drained();
    configure(debounce, long_t, dbl_t, rpt_t, press_lvl, poke_spare);
    @(negedge clk_i);
    gap_pct = gap;
    repeat (n) key_cmd_q.push_back(random_cmd());
  endtask

  // Driver: a transaction is taken at a rising edge with start high and busy low.
  // Predict it there, then either present the next command or drop start for a gap.
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    key_cmd_t nxt;
    logic     taken;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        report_q.push_back(predict_report({kind_i, key_levels_i, key_number_i, event_mask_i}));
        if (kind_i == KIND_TICK) begin
          n_ticks++;
        end else begin
          n_checks++;
        end
      end
      // Only touch start when the current transaction is gone, so it never dips.
      if (!start || taken) begin
        if (key_cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = key_cmd_q.pop_front();
          kind_i       <= nxt.kind;
          key_levels_i <= nxt.levels;
          key_number_i <= nxt.key;
          event_mask_i <= nxt.mask;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result is matched against the oldest awaited report.
  always @(posedge clk_i) begin : result_monitor
    flag_report_t exp_rep;
    if (rst_ni && valid_o === 1'b1) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result, hit %b flags_now %h", $time, hit_o, flags_now_o);
        n_errors++;
      end else begin
        exp_rep = report_q.pop_front();
        if (hit_o !== exp_rep.hit) begin
          $display("%0t: hit mismatch, expected %b actual %b", $time, exp_rep.hit, hit_o);
          n_errors++;
        end
        if (flags_now_o !== exp_rep.flags) begin
          $display("%0t: flags_now mismatch, expected %h actual %h",
                   $time, exp_rep.flags, flags_now_o);
          n_errors++;
        end
        if (hit_o === 1'b1) n_hits++;
      end
    end else if (rst_ni && valid_o !== 1'b0) begin
      $display("%0t: valid_o unknown, expected 0 actual %b", $time, valid_o);
      n_errors++;
    end
  end

  initial begin : stimulus
    int i;
    shadow_reset();
    for (i = 0; i < LEVEL_W; i++) gen_run[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: nothing is flagged yet, and the tenth tick takes the first
    // sample with every line pressed. Tick reports also cover out-of-range key numbers.
    key_cmd_q.push_back(check_cmd(8'd0, '1));
    for (i = 0; i < 10; i++) key_cmd_q.push_back(tick_cmd('0, 8'(i)));
    key_cmd_q.push_back(check_cmd(8'd0, EV_HOLD));
    key_cmd_q.push_back(check_cmd(8'd1, EV_HOLD | EV_DOWN));
    key_cmd_q.push_back(check_cmd(8'd2, '0));
    wait_drained();

    // Sample every tick with zero timer loads: walk release, single, press, long,
    // repeat, release, then a double click, one sample per step.
    configure(8'd0, '0, '0, '0, 1'b0, 1'b0);
    @(negedge clk_i);
    key_cmd_q.push_back(tick_cmd('1, 8'd5));
    key_cmd_q.push_back(tick_cmd('1, 8'd5));
    key_cmd_q.push_back(tick_cmd('0, 8'd6));
    key_cmd_q.push_back(tick_cmd('0, 8'd6));
    key_cmd_q.push_back(tick_cmd('0, 8'd6));
    key_cmd_q.push_back(check_cmd(8'd6, '1));
    key_cmd_q.push_back(tick_cmd('1, 8'd7));
    key_cmd_q.push_back(tick_cmd('0, 8'd3));
    key_cmd_q.push_back(tick_cmd('1, 8'd3));
    key_cmd_q.push_back(tick_cmd('0, 8'd3));
    key_cmd_q.push_back(tick_cmd('1, 8'd3));
    key_cmd_q.push_back(check_cmd(8'd200, '1));

    // Random phases: gap rate, debounce, long, double, repeat, polarity, spare poke, count.
    run_phase(0,  8'd1,   16'd3,     16'd2,     16'd2,     1'b0, 1'b0, 290);
    run_phase(81, 8'd0,   16'd0,     16'd0,     16'd0,     1'b1, 1'b0, 290);
    run_phase(34, 8'd3,   16'd10,    16'd6,     16'd4,     1'b0, 1'b1, 290);
    run_phase(0,  8'd2,   16'd5,     16'd20,    16'd1,     1'b1, 1'b0, 290);
    run_phase(81, 8'd255, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 1'b0, 370);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (report_q.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, report_q.size());
      n_errors++;
    end

    $display("Ran %0d ticks and %0d checks (%0d hits) across seven register settings,",
             n_ticks, n_checks, n_hits);
    $display("including zero timer loads, both polarities and full-scale values; %0d errors.",
             n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
